// ----- hw/rtl/dmx_frame_triple_buffer_unit_macros.svh -----
// Assertion macros for the frame triple buffer RTL.
`ifndef DMX_FRAME_TRIPLE_BUFFER_UNIT_MACROS_SVH
`define DMX_FRAME_TRIPLE_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DMXTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DMXTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dmxtb_pkg.sv -----
// Shared types and constants for the frame triple buffer.
`timescale 1ns / 1ps
`default_nettype none
package dmxtb_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_COMMIT  = 2'd1,
    OP_ACQUIRE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // Buffer index held by a role (back, middle, front).
  typedef logic [1:0] role_t;

  localparam role_t ROLE_BACK_RST   = 2'd0;
  localparam role_t ROLE_MIDDLE_RST = 2'd1;
  localparam role_t ROLE_FRONT_RST  = 2'd2;

  localparam int DATA_W      = 8;
  localparam int TAG_PORT_W  = 32;
  localparam int IDX_W       = 9;
  localparam int SLOT_PORT_W = 10;

  typedef logic [DATA_W-1:0]      data_t;
  typedef logic [TAG_PORT_W-1:0]  tag_port_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [SLOT_PORT_W-1:0] slot_port_t;

  // Per-beat status handed from control to the output stage.
  typedef struct packed {
    logic       read_hit;
    slot_port_t front_slots;
    tag_port_t  front_tag;
    slot_port_t posted_slots;
    tag_port_t  posted_tag;
    logic       took_new;
    logic       dropped;
  } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dmxtb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dmxtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1536,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hw/rtl/dmxtb_ctrl.sv -----
// Role indices, slot counts, tags and frame store addressing.
`timescale 1ns / 1ps
`default_nettype none
`include "dmx_frame_triple_buffer_unit_macros.svh"
module dmxtb_ctrl #(
  parameter int MAX_SLOTS = 512,
  parameter int TAG_BITS  = 32,
  localparam int AW = $clog2(3 * MAX_SLOTS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [1:0]         opcode,
  input  wire dmxtb_pkg::data_t   data_byte,
  input  wire dmxtb_pkg::tag_port_t frame_tag,
  input  wire dmxtb_pkg::idx_t    read_index,
  output logic                    busy,
  output logic                    out_valid,
  output dmxtb_pkg::result_t      result,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output dmxtb_pkg::data_t        mem_wdata,
  output logic                    mem_re,
  output logic [AW-1:0]           mem_raddr
);

  localparam int PW = $clog2(MAX_SLOTS + 1);
  localparam int TW = (TAG_BITS < dmxtb_pkg::TAG_PORT_W) ? TAG_BITS : dmxtb_pkg::TAG_PORT_W;

  dmxtb_pkg::role_t back_r, back_nxt, mid_r, mid_nxt, front_r, front_nxt;
  logic              fresh_r, fresh_nxt;
  logic [PW-1:0]     ptr_r, ptr_nxt;
  logic [PW-1:0]     slots_r [3];
  logic [PW-1:0]     slots_nxt [3];
  logic [TW-1:0]     tags_r [3];
  logic [TW-1:0]     tags_nxt [3];
  logic [PW-1:0]     post_slots_r, post_slots_nxt;
  logic [TW-1:0]     post_tag_r, post_tag_nxt;
  logic              busy_r;
  logic              out_valid_r;
  dmxtb_pkg::result_t res_r, res_nxt;

  logic              accept;
  dmxtb_pkg::op_t    op;
  logic              hit;
  logic              took;
  logic              drop;

  logic              roles_ok;
  logic              take_commit;
  logic              take_fresh;

  function automatic logic [AW-1:0] base_of(dmxtb_pkg::role_t r);
    logic [AW-1:0] b;
    case (r)
      2'd1:    b = AW'(MAX_SLOTS);
      2'd2:    b = AW'(2 * MAX_SLOTS);
      default: b = '0;
    endcase
    return b;
  endfunction

  assign accept = start && !busy_r;
  assign op     = dmxtb_pkg::op_t'(opcode);

  always_comb begin
    back_nxt       = back_r;
    mid_nxt        = mid_r;
    front_nxt      = front_r;
    fresh_nxt      = fresh_r;
    ptr_nxt        = ptr_r;
    slots_nxt      = slots_r;
    tags_nxt       = tags_r;
    post_slots_nxt = post_slots_r;
    post_tag_nxt   = post_tag_r;
    hit            = 1'b0;
    took           = 1'b0;
    drop           = 1'b0;
    mem_we         = 1'b0;
    if (accept) begin
      unique case (op)
        dmxtb_pkg::OP_LOAD: begin
          if (ptr_r < PW'(MAX_SLOTS)) begin
            mem_we  = 1'b1;
            ptr_nxt = ptr_r + PW'(1);
          end else begin
            drop = 1'b1;
          end
        end
        dmxtb_pkg::OP_COMMIT: begin
          slots_nxt[back_r] = ptr_r;
          tags_nxt[back_r]  = frame_tag[TW-1:0];
          post_slots_nxt    = ptr_r;
          post_tag_nxt      = frame_tag[TW-1:0];
          back_nxt          = mid_r;
          mid_nxt           = back_r;
          fresh_nxt         = 1'b1;
          ptr_nxt           = '0;
        end
        dmxtb_pkg::OP_ACQUIRE: begin
          if (fresh_r) begin
            mid_nxt   = front_r;
            front_nxt = mid_r;
            fresh_nxt = 1'b0;
            took      = 1'b1;
          end
        end
        dmxtb_pkg::OP_READ: begin
          hit = (int'(read_index) < int'(slots_r[front_r])) &&
                (int'(read_index) < MAX_SLOTS);
        end
        default: ;
      endcase
    end
  end

  assign mem_waddr = base_of(back_r) + AW'(ptr_r);
  assign mem_wdata = data_byte;
  assign mem_re    = hit;
  assign mem_raddr = base_of(front_r) + AW'(read_index);

  always_comb begin
    res_nxt.read_hit     = hit;
    res_nxt.front_slots  = dmxtb_pkg::slot_port_t'(slots_nxt[front_nxt]);
    res_nxt.front_tag    = dmxtb_pkg::tag_port_t'(tags_nxt[front_nxt]);
    res_nxt.posted_slots = dmxtb_pkg::slot_port_t'(post_slots_nxt);
    res_nxt.posted_tag   = dmxtb_pkg::tag_port_t'(post_tag_nxt);
    res_nxt.took_new     = took;
    res_nxt.dropped      = drop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      back_r       <= dmxtb_pkg::ROLE_BACK_RST;
      mid_r        <= dmxtb_pkg::ROLE_MIDDLE_RST;
      front_r      <= dmxtb_pkg::ROLE_FRONT_RST;
      fresh_r      <= 1'b0;
      ptr_r        <= '0;
      slots_r      <= '{default: '0};
      tags_r       <= '{default: '0};
      post_slots_r <= '0;
      post_tag_r   <= '0;
      busy_r       <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      back_r       <= back_nxt;
      mid_r        <= mid_nxt;
      front_r      <= front_nxt;
      fresh_r      <= fresh_nxt;
      ptr_r        <= ptr_nxt;
      slots_r      <= slots_nxt;
      tags_r       <= tags_nxt;
      post_slots_r <= post_slots_nxt;
      post_tag_r   <= post_tag_nxt;
      busy_r       <= 1'b0;
      out_valid_r  <= accept;
    end
  end

  // Result payload: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign result    = res_r;

  assign roles_ok    = (back_r != mid_r) && (mid_r != front_r) && (back_r != front_r);
  assign take_commit = accept && (op == dmxtb_pkg::OP_COMMIT);
  assign take_fresh  = accept && (op == dmxtb_pkg::OP_ACQUIRE) && fresh_r;

  `DMXTB_ASSERT_NOW(a_roles_distinct, 1'b1, roles_ok, "buffer roles collide")
  `DMXTB_ASSERT_NOW(a_ptr_bound, 1'b1, ptr_r <= PW'(MAX_SLOTS), "load pointer past capacity")
  `DMXTB_ASSERT_NEXT(a_commit_fresh, take_commit, fresh_r && (ptr_r == '0), "commit not posted")
  `DMXTB_ASSERT_NEXT(a_acquire_take, take_fresh, res_r.took_new && !fresh_r, "acquire missed")
  `DMXTB_ASSERT_NEXT(a_one_result, accept, out_valid_r, "accepted beat gave no result")

endmodule
`default_nettype wire

// ----- hw/rtl/dmx_frame_triple_buffer_unit.sv -----
// Top level of the lighting-frame triple buffer.
`timescale 1ns / 1ps
`default_nettype none
// Triple buffer for lighting-channel frames. A beat is taken on any clock
// edge with start high and busy low; busy is high only in reset and in the
// first cycle after it, so one beat per cycle is sustained. Every beat (load,
// commit, acquire, read) gives exactly one result, strobed by out_valid
// for one cycle, in the cycle after the beat was taken. The receiver cannot
// stall: capture out_* whenever out_valid is high. The result timing is
// set by the registered read port of the frame store RAM, which holds
// all three frames (3 x MAX_SLOTS bytes). Loads write the back frame and
// reads read the front frame, which are always distinct buffers, so no
// forwarding or interlock is needed. The store is not cleared after reset;
// reads only reach bytes below the front frame's slot count, which were
// written when that frame was built. Bytes loaded past MAX_SLOTS are
// discarded and flagged with out_dropped. Reads at or past the front slot
// count, and every non-read beat, return out_read_value of zero.
module dmx_frame_triple_buffer_unit #(
  parameter int MAX_SLOTS = 512,
  parameter int TAG_BITS  = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_opcode,
  input  wire dmxtb_pkg::data_t        in_data_byte,
  input  wire dmxtb_pkg::tag_port_t    in_frame_tag,
  input  wire dmxtb_pkg::idx_t         in_read_index,
  output logic                         out_valid,
  output dmxtb_pkg::data_t             out_read_value,
  output dmxtb_pkg::slot_port_t        out_front_slots,
  output dmxtb_pkg::tag_port_t         out_front_tag,
  output dmxtb_pkg::slot_port_t        out_posted_slots,
  output dmxtb_pkg::tag_port_t         out_posted_tag,
  output logic                         out_took_new,
  output logic                         out_dropped
);

  localparam int DEPTH = 3 * MAX_SLOTS;
  localparam int AW    = $clog2(DEPTH);

  dmxtb_pkg::result_t res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  dmxtb_pkg::data_t   mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  dmxtb_pkg::data_t   mem_rdata;

  // Roles, per-buffer slot counts and tags, store addressing.
  dmxtb_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .TAG_BITS  (TAG_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .opcode     (in_opcode),
    .data_byte  (in_data_byte),
    .frame_tag  (in_frame_tag),
    .read_index (in_read_index),
    .busy       (busy),
    .out_valid  (out_valid),
    .result     (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr)
  );

  // All three frames live here, frame n at offset n * MAX_SLOTS.
  dmxtb_ram #(
    .WIDTH (dmxtb_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // RAM data lines up with the result register; zero when no hit.
  assign out_read_value   = res.read_hit ? mem_rdata : '0;
  assign out_front_slots  = res.front_slots;
  assign out_front_tag    = res.front_tag;
  assign out_posted_slots = res.posted_slots;
  assign out_posted_tag   = res.posted_tag;
  assign out_took_new     = res.took_new;
  assign out_dropped      = res.dropped;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the lighting-frame triple buffer unit.
`timescale 1ns / 1ps
`default_nettype none
// Beats go in on start/busy; every beat gives exactly one result beat,
// strobed by out_valid. The receiver cannot stall, so results are checked
// on every out_valid cycle.
//
// The prediction holds its own copy of the three frames, the role indices
// (back, middle, front), the fresh mark on the middle and the load count.
// Each accepted beat advances that copy and queues the expected result;
// each result beat is checked against the oldest entry of the queue.
//
// Stimulus:
//   - a short directed table. Rows whose result is obvious (right after
//     reset, empty frames, the all-ones tag) carry a typed-in expectation;
//     the rest go through the prediction.
//   - one frame filled to capacity and overrun, to hit the drop path.
//   - random frames: loads with reads of the front frame mixed in, a commit
//     with a random tag, then usually an acquire and a few reads. Now and
//     then a frame runs close to capacity or past it. A small share is pure noise
//     (random opcodes and fields), which also gives stale acquires, empty
//     commits and commits that are never acquired.
//
// The sender works in bursts with random gaps, plus stretches without gaps.
// A watchdog ends the run when no input beat is taken for too long.
module tb_top;

  typedef dmxtb_pkg::op_t        op_t;
  typedef dmxtb_pkg::data_t      data_t;
  typedef dmxtb_pkg::tag_port_t  tag_port_t;
  typedef dmxtb_pkg::idx_t       idx_t;
  typedef dmxtb_pkg::slot_port_t slot_port_t;
  typedef dmxtb_pkg::role_t      role_t;

  localparam int FRAME_LEN      = 512;   // slots per frame
  localparam int N_ITEMS        = 1450;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no input beat
  localparam int DRAIN_CYCLES   = 4;     // drain margin after the queue empties

  typedef struct packed {
    data_t      read_value;
    slot_port_t front_slots;
    tag_port_t  front_tag;
    slot_port_t posted_slots;
    tag_port_t  posted_tag;
    logic       took_new;
    logic       dropped;
  } beat_res_t;

  typedef struct packed {
    op_t       op;
    data_t     data;
    tag_port_t tag;
    idx_t      index;
    logic      pinned;  // res is typed in, not predicted
    beat_res_t res;
  } stim_row_t;

  localparam beat_res_t NO_RES = '0;
  localparam tag_port_t ALL1   = 32'hFFFF_FFFF;

  // Directed part. Row order matters: each row builds on the state the
  // previous ones left behind.
  localparam int N_ROWS = 24;
  localparam stim_row_t DIR_ROWS [N_ROWS] = '{
    // right after reset: empty front, nothing posted
    '{dmxtb_pkg::OP_READ,    8'h00, 32'h0, 9'd0,   1'b1, NO_RES},
    // stale acquire
    '{dmxtb_pkg::OP_ACQUIRE, 8'hFF, ALL1,  9'h1FF, 1'b1, NO_RES},
    '{dmxtb_pkg::OP_LOAD,    8'hFF, ALL1,  9'h1FF, 1'b1, NO_RES},
    '{dmxtb_pkg::OP_LOAD,    8'h00, 32'h0, 9'd0,   1'b1, NO_RES},
    // commit two bytes with the all-ones tag
    '{dmxtb_pkg::OP_COMMIT,  8'hFF, ALL1,  9'h1FF, 1'b1,
      '{8'h00, 10'd0, 32'h0, 10'd2, ALL1, 1'b0, 1'b0}},
    // front is still the empty frame until acquire
    '{dmxtb_pkg::OP_READ,    8'h00, 32'h0, 9'd0,   1'b1,
      '{8'h00, 10'd0, 32'h0, 10'd2, ALL1, 1'b0, 1'b0}},
    '{dmxtb_pkg::OP_ACQUIRE, 8'h00, 32'h0, 9'd0,   1'b1,
      '{8'h00, 10'd2, ALL1, 10'd2, ALL1, 1'b1, 1'b0}},
    // second acquire finds nothing new
    '{dmxtb_pkg::OP_ACQUIRE, 8'h00, 32'h0, 9'd0,   1'b1,
      '{8'h00, 10'd2, ALL1, 10'd2, ALL1, 1'b0, 1'b0}},
    '{dmxtb_pkg::OP_READ,    8'h00, 32'h0, 9'd0,   1'b1,
      '{8'hFF, 10'd2, ALL1, 10'd2, ALL1, 1'b0, 1'b0}},
    '{dmxtb_pkg::OP_READ,    8'hFF, ALL1,  9'd1,   1'b1,
      '{8'h00, 10'd2, ALL1, 10'd2, ALL1, 1'b0, 1'b0}},
    // at and far past the slot count: zero
    '{dmxtb_pkg::OP_READ,    8'h00, 32'h0, 9'd2,   1'b1,
      '{8'h00, 10'd2, ALL1, 10'd2, ALL1, 1'b0, 1'b0}},
    '{dmxtb_pkg::OP_READ,    8'h00, 32'h0, 9'h1FF, 1'b1,
      '{8'h00, 10'd2, ALL1, 10'd2, ALL1, 1'b0, 1'b0}},
    // empty commit, tag zero
    '{dmxtb_pkg::OP_COMMIT,  8'hFF, 32'h0, 9'h1FF, 1'b1,
      '{8'h00, 10'd2, ALL1, 10'd0, 32'h0, 1'b0, 1'b0}},
    '{dmxtb_pkg::OP_ACQUIRE, 8'h00, 32'h0, 9'd0,   1'b1,
      '{8'h00, 10'd0, 32'h0, 10'd0, 32'h0, 1'b1, 1'b0}},
    '{dmxtb_pkg::OP_READ,    8'h00, 32'h0, 9'd0,   1'b1, NO_RES},
    // from here on the prediction decides
    '{dmxtb_pkg::OP_LOAD,    8'h5A, 32'h0000_00A5, 9'd7,   1'b0, NO_RES},
    '{dmxtb_pkg::OP_LOAD,    8'hA5, 32'h8000_0000, 9'd256, 1'b0, NO_RES},
    '{dmxtb_pkg::OP_LOAD,    8'h3C, 32'h0000_0001, 9'd3,   1'b0, NO_RES},
    '{dmxtb_pkg::OP_COMMIT,  8'h81, 32'h1234_5678, 9'd1,   1'b0, NO_RES},
    // byte for the next frame, loaded before the acquire
    '{dmxtb_pkg::OP_LOAD,    8'h81, 32'h0,         9'd0,   1'b0, NO_RES},
    '{dmxtb_pkg::OP_ACQUIRE, 8'h00, 32'hDEAD_BEEF, 9'd0,   1'b0, NO_RES},
    '{dmxtb_pkg::OP_READ,    8'h00, 32'h0,         9'd1,   1'b0, NO_RES},
    '{dmxtb_pkg::OP_READ,    8'h00, 32'h0,         9'd2,   1'b0, NO_RES},
    '{dmxtb_pkg::OP_READ,    8'h00, 32'h0,         9'd3,   1'b0, NO_RES}
  };

  logic       clk   = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  op_t        in_opcode     = dmxtb_pkg::OP_LOAD;
  data_t      in_data_byte  = '0;
  tag_port_t  in_frame_tag  = '0;
  idx_t       in_read_index = '0;
  logic       busy;
  logic       out_valid;
  data_t      out_read_value;
  slot_port_t out_front_slots;
  tag_port_t  out_front_tag;
  slot_port_t out_posted_slots;
  tag_port_t  out_posted_tag;
  logic       out_took_new;
  logic       out_dropped;

  // Typed-in expectation travelling with the beat on the input side.
  logic      pin_on  = 1'b0;
  beat_res_t pin_res = '0;

  dmx_frame_triple_buffer_unit #(
    .MAX_SLOTS(FRAME_LEN),
    .TAG_BITS (32)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_data_byte    (in_data_byte),
    .in_frame_tag    (in_frame_tag),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_front_slots (out_front_slots),
    .out_front_tag   (out_front_tag),
    .out_posted_slots(out_posted_slots),
    .out_posted_tag  (out_posted_tag),
    .out_took_new    (out_took_new),
    .out_dropped     (out_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Frame model: the three frames and who holds which role.
  // ---------------------------------------------------------------------
  data_t      frame_bytes [3*FRAME_LEN];
  slot_port_t held_slots  [3] = '{default: '0};
  tag_port_t  gen_tag     [3] = '{default: '0};
  role_t      back_idx    = dmxtb_pkg::ROLE_BACK_RST;
  role_t      mid_idx     = dmxtb_pkg::ROLE_MIDDLE_RST;
  role_t      front_idx   = dmxtb_pkg::ROLE_FRONT_RST;
  logic       mid_fresh   = 1'b0;
  int         fill_ptr    = 0;
  slot_port_t last_slots  = '0;
  tag_port_t  last_tag    = '0;

  task automatic frame_step(input op_t op, input data_t d, input tag_port_t t,
                            input idx_t ix, output beat_res_t r);
    role_t swap;
    r = '0;
    case (op)
      dmxtb_pkg::OP_LOAD: begin
        if (fill_ptr < FRAME_LEN) begin
          frame_bytes[back_idx*FRAME_LEN + fill_ptr] = d;
          fill_ptr++;
        end else begin
          r.dropped = 1'b1;  // back frame full, byte discarded
        end
      end
      dmxtb_pkg::OP_COMMIT: begin
        held_slots[back_idx] = slot_port_t'(fill_ptr);
        gen_tag[back_idx]    = t;
        last_slots           = slot_port_t'(fill_ptr);
        last_tag             = t;
        swap      = mid_idx;
        mid_idx   = back_idx;
        back_idx  = swap;
        mid_fresh = 1'b1;
        fill_ptr  = 0;
      end
      dmxtb_pkg::OP_ACQUIRE: begin
        if (mid_fresh) begin
          swap       = mid_idx;
          mid_idx    = front_idx;
          front_idx  = swap;
          mid_fresh  = 1'b0;
          r.took_new = 1'b1;
        end
      end
      default: begin  // read
        if (int'(ix) < int'(held_slots[front_idx]))
          r.read_value = frame_bytes[front_idx*FRAME_LEN + ix];
      end
    endcase
    r.front_slots  = held_slots[front_idx];
    r.front_tag    = gen_tag[front_idx];
    r.posted_slots = last_slots;
    r.posted_tag   = last_tag;
  endtask

  // ---------------------------------------------------------------------
  // Result checking. Prediction and check both run on the sampled values
  // at the rising edge; the input side is driven with NBAs, so no race.
  // ---------------------------------------------------------------------
  beat_res_t expected_q [$];
  int        errors = 0;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    beat_res_t pred;
    beat_res_t want;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, read_value %0h",
                 $time, out_read_value);
      end else begin
        want = expected_q.pop_front();
        check_field("read_value",   32'(want.read_value),   32'(out_read_value));
        check_field("front_slots",  32'(want.front_slots),  32'(out_front_slots));
        check_field("front_tag",    32'(want.front_tag),    32'(out_front_tag));
        check_field("posted_slots", 32'(want.posted_slots), 32'(out_posted_slots));
        check_field("posted_tag",   32'(want.posted_tag),   32'(out_posted_tag));
        check_field("took_new",     32'(want.took_new),     32'(out_took_new));
        check_field("dropped",      32'(want.dropped),      32'(out_dropped));
      end
    end
    // push after the pop: the beat taken now comes back next cycle
    if (rst_n && start && busy === 1'b0) begin
      frame_step(in_opcode, in_data_byte, in_frame_tag, in_read_index, pred);
      expected_q.push_back(pin_on ? pin_res : pred);
    end
  end

  // Watchdog: no input beat accepted for too long.
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender. Bursts of random length; a gap of random length may open each
  // burst. start stays high across back-to-back beats.
  // ---------------------------------------------------------------------
  int items_sent = 0;
  int burst_left = 0;
  int gap_len    = 0;

  task automatic send_beat(input op_t op, input data_t d, input tag_port_t t,
                           input idx_t ix, input logic pin = 1'b0,
                           input beat_res_t want = '0);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
    end
    burst_left--;
    if (gap_len != 0) begin
      start <= 1'b0;
      repeat (gap_len) @(posedge clk);
      gap_len = 0;
    end
    start         <= 1'b1;
    in_opcode     <= op;
    in_data_byte  <= d;
    in_frame_tag  <= t;
    in_read_index <= ix;
    pin_on        <= pin;
    pin_res       <= want;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
  endtask

  // Mostly inside the front frame, sometimes anywhere.
  function automatic idx_t pick_index();
    int fs;
    fs = int'(held_slots[front_idx]);
    if (fs != 0 && $urandom_range(0, 2) != 0)
      return idx_t'($urandom_range(0, fs - 1));
    return idx_t'($urandom_range(0, FRAME_LEN - 1));
  endfunction

  function automatic tag_port_t pick_tag();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return tag_port_t'($urandom);
    endcase
  endfunction

  initial begin
    int frame_len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i])
      send_beat(DIR_ROWS[i].op, DIR_ROWS[i].data, DIR_ROWS[i].tag,
                DIR_ROWS[i].index, DIR_ROWS[i].pinned, DIR_ROWS[i].res);

    // Full back buffer: fill every slot, then overrun.
    for (int i = 0; i < FRAME_LEN + 3; i++)
      send_beat(dmxtb_pkg::OP_LOAD, data_t'($urandom), pick_tag(), idx_t'($urandom));
    send_beat(dmxtb_pkg::OP_COMMIT, data_t'($urandom), pick_tag(), idx_t'($urandom));
    send_beat(dmxtb_pkg::OP_ACQUIRE, data_t'($urandom), pick_tag(), idx_t'($urandom));
    send_beat(dmxtb_pkg::OP_READ, data_t'($urandom), pick_tag(), idx_t'(FRAME_LEN - 1));
    send_beat(dmxtb_pkg::OP_READ, data_t'($urandom), pick_tag(), '0);

    // Random part.
    while (items_sent < N_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any opcode, any field
        repeat ($urandom_range(1, 8))
          send_beat(op_t'($urandom_range(0, 3)), data_t'($urandom), pick_tag(),
                    idx_t'($urandom));
      end else begin
        frame_len = ($urandom_range(0, 39) == 0) ? $urandom_range(FRAME_LEN - 8,
                                                                  FRAME_LEN + 4)
                                                 : $urandom_range(0, 24);
        for (int i = 0; i < frame_len; i++) begin
          if ($urandom_range(0, 3) == 0)
            send_beat(dmxtb_pkg::OP_READ, data_t'($urandom), pick_tag(), pick_index());
          send_beat(dmxtb_pkg::OP_LOAD, data_t'($urandom), pick_tag(), idx_t'($urandom));
        end
        send_beat(dmxtb_pkg::OP_COMMIT, data_t'($urandom), pick_tag(), idx_t'($urandom));
        if ($urandom_range(0, 3) != 0)
          send_beat(dmxtb_pkg::OP_ACQUIRE, data_t'($urandom), pick_tag(),
                    idx_t'($urandom));
        repeat ($urandom_range(0, 6))
          send_beat(dmxtb_pkg::OP_READ, data_t'($urandom), pick_tag(), pick_index());
      end
    end

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
`default_nettype wire
